/* rtl/core/ssv_pkg.sv */
package ssv_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int SINE_INDEX_BITS = 10;

    localparam int EL_W  = 16;
    localparam int MA_W  = 21;
    localparam int MB_W  = 18;
    localparam int MP_W  = MA_W + MB_W;
    localparam int OFS_W = 40;
    localparam int CNT_W = 32;
    localparam int SE_W  = 17;
    localparam int Q_W   = 17;

    // phase increment: 20 x 16 bit product, scaled to the accumulator width
    localparam int INC_PROD_W = 36;
    localparam int INC_SHL    = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
    localparam int INC_SHR    = (PHASE_BITS >= 32) ? 0 : 32 - PHASE_BITS;
    localparam int INC_W      = INC_PROD_W + INC_SHL;
    localparam int SUM_W      = INC_W + 1;

    localparam logic signed [OFS_W-1:0] OFS_MAX = {1'b0, {(OFS_W-1){1'b1}}};
    localparam logic signed [OFS_W-1:0] OFS_MIN = {1'b1, {(OFS_W-1){1'b0}}};

    localparam logic [Q_W-1:0]  ONE_Q16   = 17'd65536;
    localparam logic [Q_W-1:0]  SIN_C0    = 17'd307;
    localparam logic [Q_W-1:0]  SIN_C1    = 17'd5223;
    localparam logic [Q_W-1:0]  SIN_C2    = 17'd42334;
    localparam logic [Q_W-1:0]  SIN_C3    = 17'd102944;
    localparam logic [Q_W-1:0]  BRAKE_LIM = 17'd655;
    localparam logic [7:0]      SYNC_GAIN = 8'd116;
    localparam logic [SE_W-1:0] SYNC_SAT  = {SE_W{1'b1}};

    typedef enum logic [1:0] {
        MODE_SINE     = 2'd0,
        MODE_BRAKE    = 2'd1,
        MODE_RELEASED = 2'd2,
        MODE_PULSE    = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        CFG_RUN_MODE      = 3'd0,
        CFG_FREQ_STEP     = 3'd1,
        CFG_AMPLITUDE     = 3'd2,
        CFG_OFFSET_TARGET = 3'd3,
        CFG_OFFSET_RATE   = 3'd4,
        CFG_SYNC_PERIOD   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        t_mode              run_mode;
        logic [19:0]        freq_step;
        logic [15:0]        amplitude;
        logic signed [15:0] offset_target;
        logic [15:0]        offset_rate;
        logic [15:0]        sync_period;
    } t_cfg;

    typedef struct packed {
        logic signed [MA_W-1:0] a;
        logic signed [MB_W-1:0] b;
    } t_mul_req;

endpackage

/* rtl/core/sine_stepper_vibrator.sv */
// M1, M2, OFS, then ADV, X2, R1-R4, SIN, AMP, CMP, SYNC, OUT in sine mode and a running
// single pulse; brake mode and an ended pulse run X2-SIN before ADV too; released skips
// to OUT. The input stalls until OUT loads the result, which waits on a stalled output.
// The single shared multiplier gives one product per cycle; every product of the tick
// goes through it. Reset (synchronous, active low) restores the register defaults, clears
// phase, offset, position, sync timer and pulse flag, and empties the result register.
module sine_stepper_vibrator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [19:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [15:0]        i_elapsed_us,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_driver_disabled,
    output logic               o_step_pulse,
    output logic               o_step_backward,
    output logic signed [31:0] o_position_count,
    output logic               o_sync_valid,
    output logic [7:0]         o_sync_level
);

    localparam int P   = ssv_pkg::PHASE_BITS;
    localparam int SIB = ssv_pkg::SINE_INDEX_BITS;

    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_M1   = 15'b000000000000010,
        S_M2   = 15'b000000000000100,
        S_OFS  = 15'b000000000001000,
        S_ADV  = 15'b000000000010000,
        S_X2   = 15'b000000000100000,
        S_R1   = 15'b000000001000000,
        S_R2   = 15'b000000010000000,
        S_R3   = 15'b000000100000000,
        S_R4   = 15'b000001000000000,
        S_SIN  = 15'b000010000000000,
        S_AMP  = 15'b000100000000000,
        S_CMP  = 15'b001000000000000,
        S_SYNC = 15'b010000000000000,
        S_OUT  = 15'b100000000000000
    } t_state;

    ssv_pkg::t_cfg     cfg;
    ssv_pkg::t_mul_req mul_req;
    logic signed [ssv_pkg::MP_W-1:0] r_prod;

    t_state r_state, n_state;

    logic [ssv_pkg::EL_W-1:0]         r_el;
    logic [ssv_pkg::INC_W-1:0]        r_inc;
    logic [P-1:0]                     r_phase;
    logic signed [ssv_pkg::OFS_W-1:0] r_ofs;
    logic [ssv_pkg::CNT_W-1:0]        r_cnt;
    logic [ssv_pkg::SE_W-1:0]         r_sel;
    logic                             r_pd;
    logic                             r_pass;
    logic [ssv_pkg::Q_W-1:0]          r_x2;
    logic signed [ssv_pkg::MB_W-1:0]  r_sin;
    logic                             r_dis, r_step, r_back, r_sv;
    logic [7:0]                       r_lvl;

    logic               r_out_valid, r_o_dis, r_o_step, r_o_back, r_o_sv;
    logic signed [31:0] r_o_pos;
    logic [7:0]         r_o_lvl;

    ssv_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    ssv_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (r_prod)
    );

    // sine argument from the phase
    logic [SIB-1:0]          idx;
    logic [1:0]              quad;
    logic [SIB-3:0]          frac;
    logic [ssv_pkg::Q_W-1:0] x_base, x;
    logic [22:0]             prod_q;
    logic [ssv_pkg::Q_W-1:0] coef;
    logic [ssv_pkg::Q_W-1:0] s_mag;
    logic signed [ssv_pkg::MB_W-1:0] s_val;
    logic [ssv_pkg::Q_W-1:0] s_abs;

    always_comb begin
        idx    = r_phase[P-1 -: SIB];
        quad   = idx[SIB-1:SIB-2];
        frac   = idx[SIB-3:0];
        x_base = ssv_pkg::Q_W'({frac, 16'b0} >> (SIB - 2));
        x      = quad[0] ? ssv_pkg::ONE_Q16 - x_base : x_base;
        prod_q = r_prod[38:16];
        case (r_state)
            S_R2:    coef = ssv_pkg::SIN_C1 - prod_q[16:0];
            S_R3:    coef = ssv_pkg::SIN_C2 - prod_q[16:0];
            default: coef = ssv_pkg::SIN_C3 - prod_q[16:0];
        endcase
        s_mag = (prod_q > 23'(ssv_pkg::ONE_Q16)) ? ssv_pkg::ONE_Q16 : prod_q[16:0];
        s_val = quad[1] ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
        s_abs = r_sin[17] ? ssv_pkg::Q_W'(-r_sin) : ssv_pkg::Q_W'(r_sin);
    end

    // shared multiplier operand select
    always_comb begin
        mul_req.a = '0;
        mul_req.b = '0;
        case (r_state)
            S_M1: begin
                mul_req.a = ssv_pkg::MA_W'(cfg.freq_step);
                mul_req.b = ssv_pkg::MB_W'(r_el);
            end
            S_M2: begin
                mul_req.a = ssv_pkg::MA_W'(cfg.offset_rate);
                mul_req.b = ssv_pkg::MB_W'(r_el);
            end
            S_X2: begin
                mul_req.a = ssv_pkg::MA_W'(x);
                mul_req.b = ssv_pkg::MB_W'(x);
            end
            S_R1: begin
                mul_req.a = ssv_pkg::MA_W'(ssv_pkg::SIN_C0);
                mul_req.b = ssv_pkg::MB_W'(prod_q[16:0]);
            end
            S_R2, S_R3: begin
                mul_req.a = ssv_pkg::MA_W'(coef);
                mul_req.b = ssv_pkg::MB_W'(r_x2);
            end
            S_R4: begin
                mul_req.a = ssv_pkg::MA_W'(coef);
                mul_req.b = ssv_pkg::MB_W'(x);
            end
            S_AMP: begin
                mul_req.a = ssv_pkg::MA_W'(cfg.amplitude);
                mul_req.b = r_sin;
            end
            S_CMP: begin
                mul_req.a = ssv_pkg::MA_W'(ssv_pkg::SYNC_GAIN);
                mul_req.b = r_sin;
            end
            default: ;
        endcase
    end

    // offset slew and sync timer
    logic signed [41:0] ofs_e, dx_e, tgt_e, ofs_sum;
    logic               ofs_up, ofs_dn;
    logic signed [ssv_pkg::OFS_W-1:0] n_ofs;
    logic [ssv_pkg::SE_W:0]           se_sum;
    logic [ssv_pkg::SE_W-1:0]         n_sel;

    always_comb begin
        ofs_e   = 42'(r_ofs);
        dx_e    = $signed({10'b0, r_prod[31:0]});
        tgt_e   = $signed({{10{cfg.offset_target[15]}}, cfg.offset_target, 16'b0});
        ofs_up  = ofs_e < tgt_e;
        ofs_dn  = ofs_e >= tgt_e + dx_e;
        ofs_sum = ofs_up ? ofs_e + dx_e : ofs_e - dx_e;
        if (!ofs_up && !ofs_dn) begin
            n_ofs = r_ofs;
        end else if (ofs_sum > 42'(ssv_pkg::OFS_MAX)) begin
            n_ofs = ssv_pkg::OFS_MAX;
        end else if (ofs_sum < 42'(ssv_pkg::OFS_MIN)) begin
            n_ofs = ssv_pkg::OFS_MIN;
        end else begin
            n_ofs = ofs_sum[ssv_pkg::OFS_W-1:0];
        end
        se_sum = {1'b0, r_sel} + (ssv_pkg::SE_W + 1)'(r_el);
        n_sel  = se_sum[ssv_pkg::SE_W] ? ssv_pkg::SYNC_SAT : se_sum[ssv_pkg::SE_W-1:0];
    end

    // phase advance, step decision, sync level
    logic [ssv_pkg::INC_W-1:0] n_inc;
    logic [ssv_pkg::SUM_W-1:0] ph_sum;
    logic                      wrapped, adv, need_brake;
    logic signed [48:0]        tgt49, pos49;
    logic                      fwd, bwd;
    logic signed [ssv_pkg::MP_W-1:0] lvl_sum;
    logic                      out_free;

    always_comb begin
        n_inc = (ssv_pkg::INC_W'(r_prod[ssv_pkg::INC_PROD_W-1:0]) << ssv_pkg::INC_SHL)
                >> ssv_pkg::INC_SHR;
        ph_sum  = ssv_pkg::SUM_W'(r_phase) + ssv_pkg::SUM_W'(r_inc);
        wrapped = |ph_sum[ssv_pkg::SUM_W-1:P];
        need_brake = (cfg.run_mode == ssv_pkg::MODE_BRAKE)
                  || (cfg.run_mode == ssv_pkg::MODE_PULSE && r_pd);
        adv = !need_brake || (s_abs > ssv_pkg::BRAKE_LIM);
        tgt49   = 49'(r_prod) + 49'(r_ofs);
        pos49   = 49'($signed({r_cnt, 16'b0}));
        fwd     = pos49 < tgt49;
        bwd     = pos49 > tgt49 + 49'sd65536;
        lvl_sum = r_prod + 39'sd8388608;
        out_free = !r_out_valid || !i_out_stall;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_M1;
            S_M1:   n_state = S_M2;
            S_M2:   n_state = S_OFS;
            S_OFS: begin
                if (cfg.run_mode == ssv_pkg::MODE_RELEASED) n_state = S_OUT;
                else if (need_brake)                        n_state = S_X2;
                else                                        n_state = S_ADV;
            end
            S_ADV:  n_state = S_X2;
            S_X2:   n_state = S_R1;
            S_R1:   n_state = S_R2;
            S_R2:   n_state = S_R3;
            S_R3:   n_state = S_R4;
            S_R4:   n_state = S_SIN;
            S_SIN:  n_state = r_pass ? S_AMP : S_ADV;
            S_AMP:  n_state = S_CMP;
            S_CMP:  n_state = S_SYNC;
            S_SYNC: n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= '0;
            r_ofs   <= '0;
            r_cnt   <= '0;
            r_sel   <= '0;
            r_pd    <= 1'b0;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we && ssv_pkg::t_cfg_idx'(i_cfg_idx) == ssv_pkg::CFG_RUN_MODE) begin
                r_pd <= 1'b0;
            end
            case (r_state)
                S_OFS: begin
                    r_ofs  <= n_ofs;
                    r_sel  <= n_sel;
                    r_pass <= !need_brake;
                end
                S_ADV: begin
                    r_pass <= 1'b1;
                    if (adv) begin
                        r_phase <= ph_sum[P-1:0];
                        if (cfg.run_mode == ssv_pkg::MODE_PULSE && !r_pd && wrapped) begin
                            r_pd <= 1'b1;
                        end
                    end
                end
                S_CMP: begin
                    if (fwd)      r_cnt <= r_cnt + 1'b1;
                    else if (bwd) r_cnt <= r_cnt - 1'b1;
                end
                S_SYNC: if (r_sv) r_sel <= '0;
                default: ;
            endcase
        end
    end

    // payload registers of the sequencer
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: r_el <= i_elapsed_us;
            S_M2:   r_inc <= n_inc;
            S_OFS: begin
                r_dis  <= (cfg.run_mode == ssv_pkg::MODE_RELEASED);
                r_step <= 1'b0;
                r_back <= 1'b0;
                r_sv   <= 1'b0;
                r_lvl  <= '0;
            end
            S_R1:  r_x2 <= prod_q[16:0];
            S_SIN: r_sin <= s_val;
            S_CMP: begin
                r_step <= fwd || bwd;
                r_back <= !fwd && bwd;
                r_sv   <= r_sel > {1'b0, cfg.sync_period};
            end
            S_SYNC: r_lvl <= r_sv ? lvl_sum[23:16] : 8'd0;
            default: ;
        endcase
    end

    // result register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_o_dis  <= r_dis;
            r_o_step <= r_step;
            r_o_back <= r_back;
            r_o_pos  <= $signed(r_cnt);
            r_o_sv   <= r_sv;
            r_o_lvl  <= r_lvl;
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_driver_disabled = r_o_dis;
    assign o_step_pulse      = r_o_step;
    assign o_step_backward   = r_o_back;
    assign o_position_count  = r_o_pos;
    assign o_sync_valid      = r_o_sv;
    assign o_sync_level      = r_o_lvl;

    a_back_needs_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_step_backward |-> o_step_pulse)
        else $error("backward direction without a step");

    a_released_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_driver_disabled |-> !o_step_pulse && !o_sync_valid)
        else $error("step or sync while released");

    a_no_sync_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_sync_valid |-> o_sync_level == 8'd0)
        else $error("sync level nonzero without sync");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("ready again right after accepting an item");

endmodule

/* rtl/core/ssv_regs.sv */
module ssv_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [19:0]   i_cfg_data,
    output ssv_pkg::t_cfg o_cfg
);

    ssv_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.run_mode      <= ssv_pkg::MODE_RELEASED;
            r_cfg.freq_step     <= 20'd4295;
            r_cfg.amplitude     <= 16'd204;
            r_cfg.offset_target <= 16'sd0;
            r_cfg.offset_rate   <= 16'd267;
            r_cfg.sync_period   <= 16'd500;
        end else if (i_cfg_we) begin
            case (ssv_pkg::t_cfg_idx'(i_cfg_idx))
                ssv_pkg::CFG_RUN_MODE:      r_cfg.run_mode <= ssv_pkg::t_mode'(i_cfg_data[1:0]);
                ssv_pkg::CFG_FREQ_STEP:     r_cfg.freq_step <= i_cfg_data;
                ssv_pkg::CFG_AMPLITUDE:     r_cfg.amplitude <= i_cfg_data[15:0];
                ssv_pkg::CFG_OFFSET_TARGET: r_cfg.offset_target <= $signed(i_cfg_data[15:0]);
                ssv_pkg::CFG_OFFSET_RATE:   r_cfg.offset_rate <= i_cfg_data[15:0];
                ssv_pkg::CFG_SYNC_PERIOD:   r_cfg.sync_period <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/core/ssv_mul.sv */
module ssv_mul (
    input  logic                              i_clk,
    input  ssv_pkg::t_mul_req                 i_req,
    output logic signed [ssv_pkg::MP_W-1:0]   o_prod
);

    logic signed [ssv_pkg::MP_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= ssv_pkg::MP_W'(i_req.a) * ssv_pkg::MP_W'(i_req.b);
    end

    assign o_prod = r_prod;

endmodule

/* verif/tb_sine_stepper_vibrator.sv */
`timescale 1ns / 1ps

module tb_sine_stepper_vibrator;
    import ssv_pkg::*;

    localparam int     QUIET_LIMIT    = 5000;
    localparam int     HOLD_CYCLES    = 300;
    localparam longint SYNC_TIMER_MAX = 131071;

    typedef struct packed {
        logic        disabled;
        logic        pulse;
        logic        backward;
        logic [31:0] pos;
        logic        sv;
        logic [7:0]  lvl;
    } t_tick;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_cfg_we     = 1'b0;
    logic [2:0]         i_cfg_idx    = '0;
    logic [19:0]        i_cfg_data   = '0;
    logic               i_in_valid   = 1'b0;
    logic [15:0]        i_elapsed_us = '0;
    logic               i_out_stall  = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic               o_driver_disabled;
    logic               o_step_pulse;
    logic               o_step_backward;
    logic signed [31:0] o_position_count;
    logic               o_sync_valid;
    logic [7:0]         o_sync_level;

    // mirror of the block's registers and state
    t_cfg                  cfg;
    logic [PHASE_BITS-1:0] phase_now;
    longint                offset_q16;
    logic [31:0]           position;
    longint                sync_timer;
    logic                  pulse_finished;
    t_tick                 expected_ticks[$];

    int mismatches   = 0;
    int quiet_cycles = 0;
    int stall_pct    = 0;
    int hold_req     = 0;
    int hold_left    = 0;
    int max_gap      = 0;
    int burst_left   = 0;

    sine_stepper_vibrator u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_elapsed_us      (i_elapsed_us),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_driver_disabled (o_driver_disabled),
        .o_step_pulse      (o_step_pulse),
        .o_step_backward   (o_step_backward),
        .o_position_count  (o_position_count),
        .o_sync_valid      (o_sync_valid),
        .o_sync_level      (o_sync_level)
    );

    always #1 i_clk = ~i_clk;

    function automatic longint phase_to_sine(input logic [PHASE_BITS-1:0] ph);
        logic [SINE_INDEX_BITS-1:0] idx;
        longint x, x2, r, s;
        idx = ph[PHASE_BITS-1 -: SINE_INDEX_BITS];
        x = (longint'(idx[SINE_INDEX_BITS-3:0]) << 16) >> (SINE_INDEX_BITS - 2);
        // mirror the odd quadrants
        if (idx[SINE_INDEX_BITS-2])
            x = 65536 - x;
        x2 = (x * x) >> 16;
        r = 5223 - ((307 * x2) >> 16);
        r = 42334 - ((r * x2) >> 16);
        r = 102944 - ((r * x2) >> 16);
        s = (r * x) >> 16;
        if (s > 65536)
            s = 65536;
        return idx[SINE_INDEX_BITS-1] ? -s : s;
    endfunction

    function automatic logic advance_phase(input longint inc);
        longint sum;
        sum = longint'(phase_now) + inc;
        phase_now = sum[PHASE_BITS-1:0];
        return (sum >> PHASE_BITS) != 0;
    endfunction

    function automatic longint clamp_offset(input longint v);
        if (v > longint'(OFS_MAX))
            return longint'(OFS_MAX);
        if (v < longint'(OFS_MIN))
            return longint'(OFS_MIN);
        return v;
    endfunction

    function automatic t_tick stepper_tick(input logic [15:0] el);
        t_tick  res;
        longint dx, goal, inc, s, mag, target, pos, lvl;
        res = '0;
        dx = longint'(cfg.offset_rate) * longint'(el);
        goal = longint'(cfg.offset_target) * 65536;
        // slew toward the goal, a step may overshoot it
        if (offset_q16 < goal)
            offset_q16 = clamp_offset(offset_q16 + dx);
        else if (offset_q16 >= goal + dx)
            offset_q16 = clamp_offset(offset_q16 - dx);
        sync_timer = sync_timer + longint'(el);
        if (sync_timer > SYNC_TIMER_MAX)
            sync_timer = SYNC_TIMER_MAX;
        if (cfg.run_mode == MODE_RELEASED) begin
            res.disabled = 1'b1;
            res.pos = position;
            return res;
        end
        inc = (longint'(cfg.freq_step) * longint'(el) << INC_SHL) >> INC_SHR;
        s = phase_to_sine(phase_now);
        mag = (s < 0) ? -s : s;
        if (cfg.run_mode == MODE_SINE) begin
            void'(advance_phase(inc));
        end else if (cfg.run_mode == MODE_PULSE && !pulse_finished) begin
            if (advance_phase(inc))
                pulse_finished = 1'b1;
        end else if (mag * 100 > 65536) begin
            void'(advance_phase(inc));
        end
        s = phase_to_sine(phase_now);
        target = longint'(cfg.amplitude) * s + offset_q16;
        pos = longint'($signed(position));
        if (pos * 65536 < target) begin
            position = position + 1;
            res.pulse = 1'b1;
        end else if (pos * 65536 > target + 65536) begin
            position = position - 1;
            res.pulse = 1'b1;
            res.backward = 1'b1;
        end
        res.pos = position;
        if (sync_timer > longint'(cfg.sync_period)) begin
            lvl = (116 * s + 128 * 65536) >> 16;
            res.sv = 1'b1;
            res.lvl = lvl[7:0];
            sync_timer = 0;
        end
        return res;
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [19:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_RUN_MODE: begin
                cfg.run_mode = t_mode'(data[1:0]);
                pulse_finished = 1'b0;
            end
            CFG_FREQ_STEP:     cfg.freq_step = data;
            CFG_AMPLITUDE:     cfg.amplitude = data[15:0];
            CFG_OFFSET_TARGET: cfg.offset_target = data[15:0];
            CFG_OFFSET_RATE:   cfg.offset_rate = data[15:0];
            CFG_SYNC_PERIOD:   cfg.sync_period = data[15:0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_mode(input t_mode mode);
        write_reg(CFG_RUN_MODE, {18'd0, mode});
    endtask

    task automatic send_tick(input logic [15:0] el);
        if (burst_left == 0 && max_gap > 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, max_gap)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end else if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_elapsed_us <= el;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        expected_ticks.push_back(stepper_tick(el));
    endtask

    // drop valid and hold until every result is back
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_ticks.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_elapsed();
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom);
            default: return 16'($urandom_range(1, 40));
        endcase
    endfunction

    task automatic apply_setting(input t_mode mode, input int kind);
        logic [19:0] f;
        logic [15:0] amp, tgt, rate, per;
        if (kind == 0) begin
            f = 20'hFFFFF; amp = 16'hFFFF; tgt = 16'h7FFF; rate = 16'hFFFF; per = 16'hFFFF;
        end else if (kind == 1) begin
            f = '0; amp = '0; tgt = 16'h8000; rate = '0; per = '0;
        end else begin
            case ($urandom_range(3))
                0:       f = 20'($urandom_range(1, 200));
                1:       f = 20'($urandom_range(200, 60000));
                2:       f = 20'($urandom);
                default: f = 20'($urandom_range(0, 3));
            endcase
            amp  = ($urandom_range(2) != 0) ? 16'($urandom_range(0, 300)) : 16'($urandom);
            tgt  = ($urandom_range(2) != 0) ? 16'(int'($urandom_range(0, 400)) - 200)
                                            : 16'($urandom);
            rate = ($urandom_range(1) != 0) ? 16'($urandom_range(0, 2000)) : 16'($urandom);
            case ($urandom_range(2))
                0:       per = 16'($urandom_range(0, 100));
                1:       per = 16'($urandom_range(0, 2000));
                default: per = 16'($urandom);
            endcase
        end
        write_reg(CFG_FREQ_STEP, f);
        write_reg(CFG_AMPLITUDE, {4'd0, amp});
        write_reg(CFG_OFFSET_TARGET, {4'd0, tgt});
        write_reg(CFG_OFFSET_RATE, {4'd0, rate});
        write_reg(CFG_SYNC_PERIOD, {4'd0, per});
        set_mode(mode);
    endtask

    // reset values: driver released, timer saturates with no sync
    task automatic test_released_defaults();
        send_tick(16'd0);
        repeat (3) send_tick(16'hFFFF);
        wait_idle();
    endtask

    task automatic test_directed_corners();
        // huge increment wraps the phase many times per item
        write_reg(CFG_FREQ_STEP, 20'hFFFFF);
        write_reg(CFG_SYNC_PERIOD, 20'd0);
        set_mode(MODE_SINE);
        send_tick(16'hFFFF);
        send_tick(16'd0);
        send_tick(16'd1);
        send_tick(16'h5555);
        send_tick(16'hAAAA);
        wait_idle();
        // brake near a zero crossing
        write_reg(CFG_FREQ_STEP, 20'd4295);
        set_mode(MODE_BRAKE);
        repeat (6) send_tick(16'd20000);
        wait_idle();
        // one period, then brake until the mode is written again
        write_reg(CFG_FREQ_STEP, 20'hFFFFF);
        set_mode(MODE_PULSE);
        repeat (3) send_tick(16'hFFFF);
        wait_idle();
        set_mode(MODE_PULSE);
        send_tick(16'd3000);
        wait_idle();
        // offset slews between both ends of the target range
        write_reg(CFG_AMPLITUDE, 20'hFFFF);
        write_reg(CFG_OFFSET_RATE, 20'hFFFF);
        write_reg(CFG_OFFSET_TARGET, 20'h07FFF);
        send_tick(16'hFFFF);
        wait_idle();
        write_reg(CFG_OFFSET_TARGET, 20'h08000);
        send_tick(16'hFFFF);
        send_tick(16'hFFFF);
        wait_idle();
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 9; p++) begin
            apply_setting((p < 8) ? t_mode'(p % 4) : t_mode'($urandom_range(3)), p);
            case ($urandom_range(3))
                0:       stall_pct = 0;
                1:       stall_pct = 20;
                2:       stall_pct = 50;
                default: stall_pct = 80;
            endcase
            case ($urandom_range(2))
                0:       max_gap = 0;
                1:       max_gap = 3;
                default: max_gap = 12;
            endcase
            repeat (120) send_tick(rand_elapsed());
            wait_idle();
        end
    endtask

    // receiver holds off while the sender keeps offering items
    task automatic test_output_holdoff();
        apply_setting(MODE_SINE, 2);
        stall_pct = 0;
        max_gap = 0;
        hold_req = HOLD_CYCLES;
        repeat (60) send_tick(rand_elapsed());
        wait_idle();
    endtask

    task automatic test_sender_pause();
        stall_pct = 30;
        max_gap = 5;
        repeat (40) send_tick(rand_elapsed());
        wait_idle();
        repeat (40) send_tick(rand_elapsed());
        wait_idle();
    endtask

    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic report_field(input string fname, input longint want, input longint got);
        $display("%0t %s expected %0d actual %0d", $time, fname, want, got);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_tick want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_ticks.size() == 0) begin
                $display("%0t result with none expected, position %0d", $time,
                         o_position_count);
                mismatches++;
            end else begin
                want = expected_ticks.pop_front();
                if (o_driver_disabled !== want.disabled)
                    report_field("driver_disabled", want.disabled, o_driver_disabled);
                if (o_step_pulse !== want.pulse)
                    report_field("step_pulse", want.pulse, o_step_pulse);
                if (o_step_backward !== want.backward)
                    report_field("step_backward", want.backward, o_step_backward);
                if (o_position_count !== want.pos)
                    report_field("position_count", $signed(want.pos), o_position_count);
                if (o_sync_valid !== want.sv)
                    report_field("sync_valid", want.sv, o_sync_valid);
                if (o_sync_level !== want.lvl)
                    report_field("sync_level", want.lvl, o_sync_level);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_sine_stepper_vibrator: errors");
                $finish;
            end
        end
    end

    initial begin
        cfg.run_mode      = MODE_RELEASED;
        cfg.freq_step     = 20'd4295;
        cfg.amplitude     = 16'd204;
        cfg.offset_target = 16'sd0;
        cfg.offset_rate   = 16'd267;
        cfg.sync_period   = 16'd500;
        phase_now      = '0;
        offset_q16     = 0;
        position       = '0;
        sync_timer     = 0;
        pulse_finished = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_released_defaults();
        test_directed_corners();
        test_random_settings();
        test_output_holdoff();
        test_sender_pause();
        wait_idle();
        repeat (25) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_sine_stepper_vibrator: clean");
        else
            $display("tb_sine_stepper_vibrator: errors");
        $finish;
    end

endmodule
